// File: hdl/array_element_address_calc_top_defines.svh
// assertion macros for the array element address calculator
`ifndef ARRAY_ELEMENT_ADDRESS_CALC_TOP_DEFINES_SVH
`define ARRAY_ELEMENT_ADDRESS_CALC_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define AEAC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("aeac: implication check failed");

// next-cycle implication, disabled during reset
`define AEAC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("aeac: next-cycle check failed");

`endif

// File: hdl/aeac_pkg.sv
// shared types and codes for the array element address calculator
package aeac_pkg;

   // item modes
   localparam logic [1:0] MODE_LOAD_DESC = 2'd0;
   localparam logic [1:0] MODE_LOAD_DIM  = 2'd1;
   localparam logic [1:0] MODE_QUERY     = 2'd2;

   // request payload
   typedef struct packed {
      logic [1:0]         mode;
      logic [3:0]         array_id;
      logic signed [31:0] base_address;
      logic [30:0]        element_size;
      logic [3:0]         dimension_count;
      logic [3:0]         dimension_index;
      logic signed [31:0] lower_bound;
      logic signed [31:0] upper_bound;
      logic signed [31:0] index_value;
      logic               last_index;
   } req_type;

   // response payload
   typedef struct packed {
      logic [3:0]         result_array_id;
      logic signed [31:0] element_address;
   } rsp_type;

endpackage

// File: hdl/aeac_ram.sv
// generic single-port-write ram with registered read
module aeac_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port, read data holds between reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/array_element_address_calc_top.sv
// Row-major array element address calculator.
// Input channel req_*: one item per transfer. Mode 0 loads an array's base,
// element size and dimension count; mode 1 loads one dimension's lower and
// upper bound; mode 2 carries one subscript of a query, first dimension first,
// and last_index marks the final subscript. Mode 3 and ids at or above
// MAX_ARRAYS are dropped.
// Output channel rsp_*: one transfer per query, carrying the array id and
// base + size * (Horner sum of (index - lower) over the extents), mod 2^32.
// A subscript passes through descriptor ram read, product and accumulate; a
// last subscript then adds a size product and a final add. One 32x32
// multiplier is shared by the extent and size products.
// req_ready is high only while the sequencer is idle.
// A finished address sits in the output register; the block keeps taking
// loads and subscripts while it waits, and stalls only when a new address is
// due while the previous one has not been taken.
// Reset clears the sequencer, accumulator, dimension counter and output valid;
// descriptor tables are not cleared and must be loaded before use.
`include "array_element_address_calc_top_defines.svh"
module array_element_address_calc_top
   import aeac_pkg::*;
#(
   parameter int MAX_ARRAYS = 16,
   parameter int MAX_DIMS = 10
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int DESC_AW = (MAX_ARRAYS > 1) ? $clog2(MAX_ARRAYS) : 1;
   localparam int DIM_DEPTH = MAX_ARRAYS * MAX_DIMS;
   localparam int DIM_AW = (DIM_DEPTH > 1) ? $clog2(DIM_DEPTH) : 1;

   typedef struct packed {
      logic [31:0] base;
      logic [30:0] size;
      logic [3:0]  dims;
   } desc_type;

   typedef struct packed {
      logic [31:0] lower;
      logic [31:0] extent;
   } dim_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_ACCUM,
      ST_SCALE,
      ST_EMIT
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] acc_ff, acc_in;
   logic [3:0]  qdim_ff, qdim_in;
   logic [31:0] prod_ff, prod_in;
   logic [31:0] idx_ff, idx_in;
   logic [3:0]  id_ff, id_in;
   logic        last_ff, last_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic               req_xfer;
   logic               id_ok;
   logic [DESC_AW-1:0] desc_addr;
   logic               desc_we;
   logic               desc_re;
   desc_type           desc_wr;
   logic [DESC_AW-1:0] desc_raddr;
   logic [3:0]         qdim_sel;
   logic [DIM_AW-1:0]  dim_waddr;
   logic [DIM_AW-1:0]  dim_raddr;
   logic               dim_we;
   dim_type            dim_wr;
   logic [66:0]        desc_rd_bits;
   logic [63:0]        dim_rd_bits;
   desc_type           desc_rd;
   dim_type            dim_rd;
   logic [31:0]        mul_a;
   logic [31:0]        mul_b;
   logic               use_dim;

   // input decode
   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign id_ok     = int'(req_data.array_id) < MAX_ARRAYS;
   assign desc_addr = DESC_AW'(req_data.array_id);

   always_comb begin
      desc_we = 1'b0;
      desc_re = 1'b0;
      dim_we  = 1'b0;
      unique case (req_data.mode)
         MODE_LOAD_DESC: desc_we = req_xfer && id_ok;
         MODE_LOAD_DIM:  dim_we  = req_xfer && id_ok
                                   && (int'(req_data.dimension_index) < MAX_DIMS);
         MODE_QUERY:     desc_re = req_xfer && id_ok;
         default: begin
         end
      endcase
   end

   // descriptor and bounds write data
   assign desc_wr.base  = req_data.base_address;
   assign desc_wr.size  = req_data.element_size;
   assign desc_wr.dims  = req_data.dimension_count;
   assign dim_wr.lower  = req_data.lower_bound;
   assign dim_wr.extent = req_data.upper_bound - req_data.lower_bound + 32'd1;

   // bounds slot addresses, read slot forced to slot 0 once the counter passes the table
   assign qdim_sel   = (int'(qdim_ff) < MAX_DIMS) ? qdim_ff : 4'd0;
   assign dim_waddr  = DIM_AW'(int'(req_data.array_id) * MAX_DIMS
                               + int'(req_data.dimension_index));
   assign dim_raddr  = DIM_AW'(int'(req_data.array_id) * MAX_DIMS + int'(qdim_sel));
   assign desc_raddr = desc_addr;

   aeac_ram #(
      .WIDTH  (67),
      .DEPTH  (MAX_ARRAYS),
      .ADDR_W (DESC_AW)
   ) u_desc_ram (
      .clock   (clock),
      .wr_en   (desc_we),
      .wr_addr (desc_addr),
      .wr_data (desc_wr),
      .rd_en   (desc_re),
      .rd_addr (desc_raddr),
      .rd_data (desc_rd_bits)
   );

   aeac_ram #(
      .WIDTH  (64),
      .DEPTH  (DIM_DEPTH),
      .ADDR_W (DIM_AW)
   ) u_dim_ram (
      .clock   (clock),
      .wr_en   (dim_we),
      .wr_addr (dim_waddr),
      .wr_data (dim_wr),
      .rd_en   (desc_re),
      .rd_addr (dim_raddr),
      .rd_data (dim_rd_bits)
   );

   assign desc_rd = desc_type'(desc_rd_bits);
   assign dim_rd  = dim_type'(dim_rd_bits);

   // shared multiplier operands: extent product, then size product
   assign mul_a = (state_ff == ST_SCALE) ? {1'b0, desc_rd.size} : acc_ff;
   assign mul_b = (state_ff == ST_SCALE) ? acc_ff : dim_rd.extent;

   // subscript counts only inside the array's dimensions
   assign use_dim = (qdim_ff < desc_rd.dims) && (int'(qdim_ff) < MAX_DIMS);

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      qdim_in      = qdim_ff;
      prod_in      = prod_ff;
      idx_in       = idx_ff;
      id_in        = id_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (desc_re) begin
               idx_in   = req_data.index_value;
               id_in    = req_data.array_id;
               last_in  = req_data.last_index;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            prod_in  = mul_a * mul_b;
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            if (use_dim) begin
               acc_in = prod_ff + (idx_ff - dim_rd.lower);
            end
            if (qdim_ff != 4'hF) begin
               qdim_in = qdim_ff + 4'd1;
            end
            state_in = last_ff ? ST_SCALE : ST_IDLE;
         end
         ST_SCALE: begin
            prod_in  = mul_a * mul_b;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.result_array_id = id_ff;
               rsp_data_in.element_address = desc_rd.base + prod_ff;
               acc_in                      = '0;
               qdim_in                     = '0;
               state_in                    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         qdim_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         qdim_ff      <= qdim_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prod_ff     <= prod_in;
      idx_ff      <= idx_in;
      id_ff       <= id_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   `AEAC_ASSERT_NXT(a_query_starts_read, clock, reset,
      req_valid && req_ready && (req_data.mode == MODE_QUERY) && id_ok,
      state_ff == ST_READ)
   `AEAC_ASSERT_IMP(a_rsp_only_from_emit, clock, reset,
      $rose(rsp_valid_ff), $past(state_ff) == ST_EMIT)
   `AEAC_ASSERT_NXT(a_query_state_cleared, clock, reset,
      (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready),
      (acc_ff == 32'd0) && (qdim_ff == 4'd0) && rsp_valid_ff)
   `AEAC_ASSERT_NXT(a_dim_counter_steps, clock, reset,
      (state_ff == ST_ACCUM) && (qdim_ff != 4'hF),
      qdim_ff == $past(qdim_ff) + 4'd1)

endmodule
